// ===== rtl/core/bcc_pkg.sv =====
// ----------------------------------------------------------------------------
// bcc_pkg
// Shared types and constants of the button click and hold classifier.
// ----------------------------------------------------------------------------
package bcc_pkg;

    localparam int TIME_W  = 32;
    localparam int CFG_W   = 16;
    localparam int EVENT_W = 3;
    localparam int INDEX_W = 2;

    localparam logic [INDEX_W-1:0] REG_DEBOUNCE   = 2'd0;
    localparam logic [INDEX_W-1:0] REG_CLICK_GAP  = 2'd1;
    localparam logic [INDEX_W-1:0] REG_SHORT_HOLD = 2'd2;
    localparam logic [INDEX_W-1:0] REG_LONG_HOLD  = 2'd3;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd20;
    localparam logic [CFG_W-1:0] CLICK_GAP_RST  = 16'd400;
    localparam logic [CFG_W-1:0] SHORT_HOLD_RST = 16'd1200;
    localparam logic [CFG_W-1:0] LONG_HOLD_RST  = 16'd4000;

    localparam logic [EVENT_W-1:0] EV_NONE   = 3'd0;
    localparam logic [EVENT_W-1:0] EV_SINGLE = 3'd1;
    localparam logic [EVENT_W-1:0] EV_DOUBLE = 3'd2;
    localparam logic [EVENT_W-1:0] EV_TRIPLE = 3'd3;
    localparam logic [EVENT_W-1:0] EV_SHORT  = 3'd4;
    localparam logic [EVENT_W-1:0] EV_LONG   = 3'd5;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_time;
        logic [CFG_W-1:0] multi_click_gap;
        logic [CFG_W-1:0] short_hold_time;
        logic [CFG_W-1:0] long_hold_time;
    } bcc_cfg_t;

    typedef struct packed {
        logic              fire;
        logic              pressed;
        logic [TIME_W-1:0] now_ms;
    } bcc_step_t;

    typedef struct packed {
        logic [EVENT_W-1:0] event_res;
        logic               idle;
    } bcc_stat_t;

endpackage

// ===== rtl/core/bcc_ifs.sv =====
// ----------------------------------------------------------------------------
// bcc_ifs
// Stream interfaces for button polls and classified events.
// ----------------------------------------------------------------------------
interface bcc_poll_if;
    import bcc_pkg::*;

    logic              valid;
    logic              ready;
    logic              pressed;
    logic [TIME_W-1:0] now_ms;

    modport source (output valid, output pressed, output now_ms, input ready);
    modport sink (input valid, input pressed, input now_ms, output ready);
endinterface

interface bcc_event_if;
    import bcc_pkg::*;

    logic               valid;
    logic               ready;
    logic [EVENT_W-1:0] event_res;

    modport source (output valid, output event_res, input ready);
    modport sink (input valid, input event_res, output ready);
endinterface

// ===== rtl/core/button_click_hold_classifier_unit.sv =====
// ----------------------------------------------------------------------------
// button_click_hold_classifier_unit
// Debounces push-button polls and classifies clicks and holds.
// ----------------------------------------------------------------------------
// Each word on the poll channel carries the raw button level and a
// free-running millisecond timestamp. Each poll yields exactly one word on
// the event channel: none, single, double or triple click, short or long hold.
// Polls are taken into an input register, classified by the phase machine once the
// result register can advance and written to the result register, which offers the
// event word. One poll per cycle is sustained while the event receiver is ready; the
// phase and timestamp registers update as each poll is classified. When the event
// receiver stalls, the result register holds its word and the input register can
// still take one more poll before poll ready falls. Reset clears both stages, returns
// the phase machine to idle with a zero timestamp and loads the default timing
// registers. The timing registers are written through cfg_we, cfg_index and cfg_data
// by the user only while no poll is in flight; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module button_click_hold_classifier_unit
(
    input  logic                        clk,
    input  logic                        rst_n,
    bcc_poll_if.sink                    poll,
    bcc_event_if.source                 evt,
    input  logic                        cfg_we,
    input  logic [bcc_pkg::INDEX_W-1:0] cfg_index,
    input  logic [bcc_pkg::CFG_W-1:0]   cfg_data
);
    import bcc_pkg::*;

    bcc_cfg_t  cfg;
    bcc_step_t step;
    bcc_stat_t stat;

    logic               in_valid_reg;
    logic               in_valid_next;
    logic               in_pressed_reg;
    logic [TIME_W-1:0]  in_now_reg;
    logic               res_valid_reg;
    logic               res_valid_next;
    logic [EVENT_W-1:0] res_event_reg;
    logic               advance;
    logic               take;

    assign advance    = !res_valid_reg || evt.ready;
    assign poll.ready = !in_valid_reg || advance;
    assign take       = poll.valid && poll.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        res_valid_next = advance ? in_valid_reg : res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_pressed_reg <= poll.pressed;
            in_now_reg     <= poll.now_ms;
        end
        if (advance && in_valid_reg)
        begin
            res_event_reg <= stat.event_res;
        end
    end

    assign step.fire    = advance && in_valid_reg;
    assign step.pressed = in_pressed_reg;
    assign step.now_ms  = in_now_reg;

    bcc_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bcc_fsm u_fsm
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .step  (step),
        .stat  (stat)
    );

    assign evt.valid     = res_valid_reg;
    assign evt.event_res = res_event_reg;

    a_ready_low_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        !poll.ready |-> (in_valid_reg && res_valid_reg))
        else $error("poll ready low with a free stage");

    a_step_fills_result: assert property (@(posedge clk) disable iff (!rst_n)
        step.fire |=> res_valid_reg)
        else $error("classified poll did not reach the result register");

    a_click_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (step.fire && (stat.event_res == EV_SINGLE || stat.event_res == EV_DOUBLE
            || stat.event_res == EV_TRIPLE)) |=> stat.idle)
        else $error("click event did not return the phase machine to idle");

    a_event_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (stat.event_res != EV_NONE) |-> !stat.idle)
        else $error("event raised from the idle phase");

endmodule

// ===== rtl/core/bcc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// bcc_cfg_regs
// Timing registers of the classifier, written through a plain write port.
// ----------------------------------------------------------------------------
module bcc_cfg_regs
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [bcc_pkg::INDEX_W-1:0] cfg_index,
    input  logic [bcc_pkg::CFG_W-1:0]   cfg_data,
    output bcc_pkg::bcc_cfg_t       cfg
);
    import bcc_pkg::*;

    bcc_cfg_t cfg_reg;
    bcc_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DEBOUNCE:   cfg_next.debounce_time   = cfg_data;
                REG_CLICK_GAP:  cfg_next.multi_click_gap = cfg_data;
                REG_SHORT_HOLD: cfg_next.short_hold_time = cfg_data;
                REG_LONG_HOLD:  cfg_next.long_hold_time  = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_time   <= DEBOUNCE_RST;
            cfg_reg.multi_click_gap <= CLICK_GAP_RST;
            cfg_reg.short_hold_time <= SHORT_HOLD_RST;
            cfg_reg.long_hold_time  <= LONG_HOLD_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/bcc_fsm.sv =====
// ----------------------------------------------------------------------------
// bcc_fsm
// Phase register, press and release timestamp and the classification logic for one poll.
// ----------------------------------------------------------------------------
module bcc_fsm
(
    input  logic               clk,
    input  logic               rst_n,
    input  bcc_pkg::bcc_cfg_t  cfg,
    input  bcc_pkg::bcc_step_t step,
    output bcc_pkg::bcc_stat_t stat
);
    import bcc_pkg::*;

    localparam logic [3:0] PH_IDLE        = 4'd0;
    localparam logic [3:0] PH_DEBOUNCE    = 4'd1;
    localparam logic [3:0] PH_PRESSED     = 4'd2;
    localparam logic [3:0] PH_REL_WAIT    = 4'd3;
    localparam logic [3:0] PH_SECOND      = 4'd4;
    localparam logic [3:0] PH_REL_WAIT2   = 4'd5;
    localparam logic [3:0] PH_THIRD       = 4'd6;
    localparam logic [3:0] PH_AFTER_SHORT = 4'd7;
    localparam logic [3:0] PH_AFTER_LONG  = 4'd8;

    logic [3:0]         phase_reg;
    logic [3:0]         phase_next;
    logic [TIME_W-1:0]  mark_reg;
    logic [TIME_W-1:0]  mark_next;
    logic [EVENT_W-1:0] event_next;
    logic [TIME_W-1:0]  elapsed;
    logic               debounce_done;
    logic               gap_done;
    logic               short_done;
    logic               long_done;

    // Elapsed time wraps modulo 2^32, so a timestamp going backwards reads as very long.
    assign elapsed       = step.now_ms - mark_reg;
    assign debounce_done = elapsed >= {{(TIME_W-CFG_W){1'b0}}, cfg.debounce_time};
    assign gap_done      = elapsed >= {{(TIME_W-CFG_W){1'b0}}, cfg.multi_click_gap};
    assign short_done    = elapsed >= {{(TIME_W-CFG_W){1'b0}}, cfg.short_hold_time};
    assign long_done     = elapsed >= {{(TIME_W-CFG_W){1'b0}}, cfg.long_hold_time};

    always_comb
    begin
        phase_next = phase_reg;
        mark_next  = mark_reg;
        event_next = EV_NONE;
        unique case (phase_reg)
            PH_DEBOUNCE:
            begin
                if (!step.pressed)
                begin
                    phase_next = PH_IDLE;
                end
                else if (debounce_done)
                begin
                    phase_next = PH_PRESSED;
                    mark_next  = step.now_ms;
                end
            end
            PH_PRESSED:
            begin
                if (!step.pressed)
                begin
                    phase_next = PH_REL_WAIT;
                    mark_next  = step.now_ms;
                end
                else if (long_done)
                begin
                    event_next = EV_LONG;
                    phase_next = PH_AFTER_LONG;
                end
                else if (short_done)
                begin
                    event_next = EV_SHORT;
                    phase_next = PH_AFTER_SHORT;
                end
            end
            PH_REL_WAIT:
            begin
                if (step.pressed)
                begin
                    phase_next = PH_SECOND;
                    mark_next  = step.now_ms;
                end
                else if (gap_done)
                begin
                    event_next = EV_SINGLE;
                    phase_next = PH_IDLE;
                end
            end
            PH_SECOND:
            begin
                if (!step.pressed)
                begin
                    phase_next = PH_REL_WAIT2;
                    mark_next  = step.now_ms;
                end
            end
            PH_REL_WAIT2:
            begin
                if (step.pressed)
                begin
                    phase_next = PH_THIRD;
                end
                else if (gap_done)
                begin
                    event_next = EV_DOUBLE;
                    phase_next = PH_IDLE;
                end
            end
            PH_THIRD:
            begin
                if (!step.pressed)
                begin
                    event_next = EV_TRIPLE;
                    phase_next = PH_IDLE;
                end
            end
            PH_AFTER_SHORT:
            begin
                if (long_done)
                begin
                    event_next = EV_LONG;
                    phase_next = PH_AFTER_LONG;
                end
                else if (!step.pressed)
                begin
                    phase_next = PH_IDLE;
                end
            end
            PH_AFTER_LONG:
            begin
                if (!step.pressed)
                begin
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                if (step.pressed)
                begin
                    mark_next  = step.now_ms;
                    phase_next = PH_DEBOUNCE;
                end
                else
                begin
                    phase_next = PH_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            mark_reg  <= '0;
        end
        else if (step.fire)
        begin
            phase_reg <= phase_next;
            mark_reg  <= mark_next;
        end
    end

    assign stat.event_res = event_next;
    assign stat.idle      = (phase_reg == PH_IDLE);

endmodule
